// ===== sv/bgc_pkg.sv =====
`default_nettype none
package bgc_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int NOW_W       = 32;
	localparam int THR_W       = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_TIME       = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DOUBLE_CLICK_WINDOW = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS_TIME     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_MEDIUM_HOLD_TIME    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_VERY_LONG_TIME      = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_VARIANT_MODE        = 3'd5;

	localparam logic [THR_W-1:0] RST_DEBOUNCE_TIME       = 16'd30;
	localparam logic [THR_W-1:0] RST_DOUBLE_CLICK_WINDOW = 16'd300;
	localparam logic [THR_W-1:0] RST_LONG_PRESS_TIME     = 16'd800;
	localparam logic [THR_W-1:0] RST_MEDIUM_HOLD_TIME    = 16'd1500;
	localparam logic [THR_W-1:0] RST_VERY_LONG_TIME      = 16'd5000;
	localparam logic             RST_VARIANT_MODE        = 1'b0;

	localparam logic OP_SAMPLE  = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	typedef enum logic [2:0] {
		GEST_NONE      = 3'd0,
		GEST_SINGLE    = 3'd1,
		GEST_DOUBLE    = 3'd2,
		GEST_LONG      = 3'd3,
		GEST_MEDIUM    = 3'd4,
		GEST_VERY_LONG = 3'd5
	} gesture_t;

	typedef struct packed {
		logic [THR_W-1:0] debounce_time;
		logic [THR_W-1:0] double_click_window;
		logic [THR_W-1:0] long_press_time;
		logic [THR_W-1:0] medium_hold_time;
		logic [THR_W-1:0] very_long_time;
		logic             variant_mode;
	} cfg_t;

endpackage
`default_nettype wire

// ===== sv/bgc_cfg.sv =====
`default_nettype none
module bgc_cfg (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire  [bgc_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  wire  [bgc_pkg::CFG_DATA_W-1:0]       cfg_data,
	output bgc_pkg::cfg_t                        cfg
);

	bgc_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time       <= bgc_pkg::RST_DEBOUNCE_TIME;
			cfg_q.double_click_window <= bgc_pkg::RST_DOUBLE_CLICK_WINDOW;
			cfg_q.long_press_time     <= bgc_pkg::RST_LONG_PRESS_TIME;
			cfg_q.medium_hold_time    <= bgc_pkg::RST_MEDIUM_HOLD_TIME;
			cfg_q.very_long_time      <= bgc_pkg::RST_VERY_LONG_TIME;
			cfg_q.variant_mode        <= bgc_pkg::RST_VARIANT_MODE;
		end else if (cfg_valid) begin
			// drop writes to unknown indexes
			case (cfg_index)
				bgc_pkg::REG_DEBOUNCE_TIME:       cfg_q.debounce_time       <= cfg_data;
				bgc_pkg::REG_DOUBLE_CLICK_WINDOW: cfg_q.double_click_window <= cfg_data;
				bgc_pkg::REG_LONG_PRESS_TIME:     cfg_q.long_press_time     <= cfg_data;
				bgc_pkg::REG_MEDIUM_HOLD_TIME:    cfg_q.medium_hold_time    <= cfg_data;
				bgc_pkg::REG_VERY_LONG_TIME:      cfg_q.very_long_time      <= cfg_data;
				bgc_pkg::REG_VARIANT_MODE:        cfg_q.variant_mode        <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== sv/bgc_core.sv =====
`default_nettype none
module bgc_core #(
	parameter int TIME_WIDTH = 32
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire  bgc_pkg::cfg_t              cfg,
	input  wire                              fire,
	input  wire                              op,
	input  wire                              pressed,
	input  wire  [bgc_pkg::NOW_W-1:0]        now_ms,
	output bgc_pkg::gesture_t                gesture
);

	typedef logic [TIME_WIDTH-1:0] tm_t;

	logic raw_candidate_q, stable_level_q, click_pending_q, in_second_press_q, long_fired_q;
	tm_t  candidate_start_q, press_start_q, click_deadline_q;

	logic raw_candidate_d, stable_level_d, click_pending_d, in_second_press_d, long_fired_d;
	tm_t  candidate_start_d, press_start_d, click_deadline_d;

	logic [63:0] now_64, deb_64, win_64, med_64, hold_64;
	tm_t         now_t, deb_t, win_t, med_t, hold_t, since_dl;

	function automatic logic reached(input tm_t now, input tm_t since, input tm_t thr);
		tm_t d;
		d = now - since;
		return !d[TIME_WIDTH-1] && (d >= thr);
	endfunction

	assign now_64  = {32'd0, now_ms};
	assign deb_64  = {48'd0, cfg.debounce_time};
	assign win_64  = {48'd0, cfg.double_click_window};
	assign med_64  = {48'd0, cfg.medium_hold_time};
	assign hold_64 = {48'd0, cfg.variant_mode ? cfg.very_long_time : cfg.long_press_time};
	assign now_t   = now_64[TIME_WIDTH-1:0];
	assign deb_t   = deb_64[TIME_WIDTH-1:0];
	assign win_t   = win_64[TIME_WIDTH-1:0];
	assign med_t   = med_64[TIME_WIDTH-1:0];
	assign hold_t  = hold_64[TIME_WIDTH-1:0];
	assign since_dl = now_t - click_deadline_q;

	always_comb begin
		raw_candidate_d   = raw_candidate_q;
		stable_level_d    = stable_level_q;
		candidate_start_d = candidate_start_q;
		press_start_d     = press_start_q;
		click_deadline_d  = click_deadline_q;
		click_pending_d   = click_pending_q;
		in_second_press_d = in_second_press_q;
		long_fired_d      = long_fired_q;
		gesture           = bgc_pkg::GEST_NONE;

		if (op == bgc_pkg::OP_RESTART) begin
			raw_candidate_d   = pressed;
			stable_level_d    = pressed;
			candidate_start_d = now_t;
			press_start_d     = now_t;
			click_deadline_d  = '0;
			click_pending_d   = 1'b0;
			in_second_press_d = 1'b0;
			long_fired_d      = 1'b0;
		end else begin
			// window ran out with no second press
			if (!stable_level_q && click_pending_q && !since_dl[TIME_WIDTH-1]) begin
				click_pending_d = 1'b0;
				gesture         = bgc_pkg::GEST_SINGLE;
			end

			if (pressed != raw_candidate_q) begin
				raw_candidate_d   = pressed;
				candidate_start_d = now_t;
			end else if (pressed != stable_level_q && reached(now_t, candidate_start_q, deb_t)) begin
				stable_level_d = pressed;
				if (pressed) begin
					press_start_d     = now_t;
					long_fired_d      = 1'b0;
					in_second_press_d = click_pending_d;
				end else if (long_fired_q) begin
					in_second_press_d = 1'b0;
				end else if (cfg.variant_mode && reached(now_t, press_start_q, med_t)) begin
					click_pending_d   = 1'b0;
					in_second_press_d = 1'b0;
					gesture           = bgc_pkg::GEST_MEDIUM;
				end else if (in_second_press_q) begin
					click_pending_d   = 1'b0;
					in_second_press_d = 1'b0;
					gesture           = bgc_pkg::GEST_DOUBLE;
				end else begin
					click_pending_d  = 1'b1;
					click_deadline_d = now_t + win_t;
				end
			end

			// held past the hold threshold: later gesture wins
			if (stable_level_d && !long_fired_d && reached(now_t, press_start_d, hold_t)) begin
				long_fired_d      = 1'b1;
				click_pending_d   = 1'b0;
				in_second_press_d = 1'b0;
				gesture           = cfg.variant_mode ? bgc_pkg::GEST_VERY_LONG
				                                     : bgc_pkg::GEST_LONG;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_candidate_q   <= 1'b0;
			stable_level_q    <= 1'b0;
			candidate_start_q <= '0;
			press_start_q     <= '0;
			click_deadline_q  <= '0;
			click_pending_q   <= 1'b0;
			in_second_press_q <= 1'b0;
			long_fired_q      <= 1'b0;
		end else if (fire) begin
			raw_candidate_q   <= raw_candidate_d;
			stable_level_q    <= stable_level_d;
			candidate_start_q <= candidate_start_d;
			press_start_q     <= press_start_d;
			click_deadline_q  <= click_deadline_d;
			click_pending_q   <= click_pending_d;
			in_second_press_q <= in_second_press_d;
			long_fired_q      <= long_fired_d;
		end
	end

`ifndef SYNTHESIS
	a_variant_only: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (gesture == bgc_pkg::GEST_MEDIUM || gesture == bgc_pkg::GEST_VERY_LONG)
		|-> cfg.variant_mode)
		else $error("variant gesture raised in standard mode");
	a_long_marks: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (gesture == bgc_pkg::GEST_LONG || gesture == bgc_pkg::GEST_VERY_LONG)
		|=> long_fired_q && !click_pending_q)
		else $error("hold gesture did not mark long_fired");
	a_restart_none: assert property (@(posedge clk) disable iff (!arst_n)
		(op == bgc_pkg::OP_RESTART) |-> gesture == bgc_pkg::GEST_NONE)
		else $error("restart beat raised a gesture");
`endif

endmodule
`default_nettype wire

// ===== sv/button_gesture_classifier.sv =====
`default_nettype none
// Button gesture classifier.
// Input channel (in_valid/in_ready): one beat per button sample, carrying op
// (sample or restart), the raw pressed level and a wrapping millisecond time.
// Output channel (out_valid/out_ready): exactly one beat per input beat,
// carrying the gesture code (none, single, double, long, medium, very long).
// Config channel (cfg_valid/cfg_ready): register index and 16-bit data; always
// ready; the user must write it only while the block is idle; the block has no check for this.
// An accepted beat is held in the input register, where the debounce/classify
// logic evaluates it combinationally against the state registers; its result
// moves into the output register once that slot is free, and out_valid is
// driven from the output register. Throughput: one beat per cycle while the
// receiver does not stall, with all subtract-compare checks between the registers.
// When the receiver stalls, the output register holds its beat and the input
// register holds one more; in_ready drops only when both are full.
// Reset clears all gesture state, empties both registers and loads the
// register defaults.
module button_gesture_classifier #(
	parameter int TIME_WIDTH = 32
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             in_valid,
	output logic                            in_ready,
	input  wire                             op,
	input  wire                             pressed,
	input  wire  [bgc_pkg::NOW_W-1:0]       now_ms,
	output logic                            out_valid,
	input  wire                             out_ready,
	output logic [2:0]                      gesture,
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire  [bgc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire  [bgc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	bgc_pkg::cfg_t     cfg;
	bgc_pkg::gesture_t gest_c, gesture_s2;
	logic                      valid_s1, valid_s2, op_s1, pressed_s1, advance;
	logic [bgc_pkg::NOW_W-1:0] now_s1;

	// the output slot frees when empty or being taken this cycle
	assign advance   = !valid_s2 || out_ready;
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = valid_s2;
	assign gesture   = gesture_s2;

	bgc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bgc_core #(.TIME_WIDTH(TIME_WIDTH)) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.fire    (valid_s1 && advance),
		.op      (op_s1),
		.pressed (pressed_s1),
		.now_ms  (now_s1),
		.gesture (gest_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1      <= op;
			pressed_s1 <= pressed;
			now_s1     <= now_ms;
		end
		if (advance && valid_s1) begin
			gesture_s2 <= gest_c;
		end
	end

`ifndef SYNTHESIS
	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> in_ready)
		else $error("input stalled with empty output register");
	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted beat lost from input register");
	a_restart_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && op_s1 == bgc_pkg::OP_RESTART
		|=> valid_s2 && gesture_s2 == bgc_pkg::GEST_NONE)
		else $error("restart beat gave a gesture");
	a_stall_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(now_s1))
		else $error("pending input beat changed while output stalled");
`endif

endmodule
`default_nettype wire

// ===== test/button_gesture_classifier_check.sv =====
`default_nettype none
module button_gesture_classifier_check (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  in_valid,
	input  wire                                  in_ready,
	input  wire                                  op,
	input  wire                                  pressed,
	input  wire  [bgc_pkg::NOW_W-1:0]            now_ms,
	input  wire                                  out_valid,
	input  wire                                  out_ready,
	input  wire  [2:0]                           gesture,
	input  wire                                  cfg_valid,
	input  wire                                  cfg_ready,
	input  wire  [bgc_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  wire  [bgc_pkg::CFG_DATA_W-1:0]       cfg_data,
	output int                                   outstanding,
	output int                                   errors
);

	localparam int TW   = bgc_pkg::NOW_W;
	localparam int HW   = bgc_pkg::THR_W;
	localparam int PADW = TW - HW;

	bgc_pkg::cfg_t     cfg;
	logic              raw_level;
	logic              stable;
	logic              click_pending;
	logic              in_second;
	logic              long_fired;
	logic [TW-1:0]     cand_start;
	logic [TW-1:0]     press_start;
	logic [TW-1:0]     click_deadline;
	bgc_pkg::gesture_t gesture_q[$];
	bgc_pkg::gesture_t want;

	initial errors = 0;

	task report_mismatch(input string msg);
		$display("%0t: %s", $time, msg);
		errors = errors + 1;
	endtask

	// Wrapping difference read as two's complement; negative never qualifies.
	function automatic logic reached(input logic [TW-1:0] t, input logic [TW-1:0] since,
			input logic [HW-1:0] thr);
		logic [TW-1:0] d;
		d = t - since;
		return !d[TW-1] && (d >= {{PADW{1'b0}}, thr});
	endfunction

	function automatic bgc_pkg::gesture_t classify_sample(input logic o, input logic lvl,
			input logic [TW-1:0] t);
		bgc_pkg::gesture_t g;
		logic [TW-1:0]     late;
		logic [HW-1:0]     hold_thr;
		g = bgc_pkg::GEST_NONE;
		if (o == bgc_pkg::OP_RESTART) begin
			raw_level = lvl;
			stable = lvl;
			cand_start = t;
			press_start = t;
			click_deadline = '0;
			click_pending = 1'b0;
			in_second = 1'b0;
			long_fired = 1'b0;
			return bgc_pkg::GEST_NONE;
		end
		late = t - click_deadline;
		if (!stable && click_pending && !late[TW-1]) begin
			click_pending = 1'b0;
			g = bgc_pkg::GEST_SINGLE;
		end
		if (lvl != raw_level) begin
			raw_level = lvl;
			cand_start = t;
		end else if (lvl != stable && reached(t, cand_start, cfg.debounce_time)) begin
			stable = lvl;
			if (lvl) begin
				press_start = t;
				long_fired = 1'b0;
				in_second = click_pending;
			end else if (long_fired) begin
				in_second = 1'b0;
			end else if (cfg.variant_mode && reached(t, press_start, cfg.medium_hold_time)) begin
				click_pending = 1'b0;
				in_second = 1'b0;
				g = bgc_pkg::GEST_MEDIUM;
			end else if (in_second) begin
				click_pending = 1'b0;
				in_second = 1'b0;
				g = bgc_pkg::GEST_DOUBLE;
			end else begin
				click_pending = 1'b1;
				click_deadline = t + {{PADW{1'b0}}, cfg.double_click_window};
			end
		end
		// Long gesture while held overrides anything raised earlier in the step.
		hold_thr = cfg.variant_mode ? cfg.very_long_time : cfg.long_press_time;
		if (stable && !long_fired && reached(t, press_start, hold_thr)) begin
			long_fired = 1'b1;
			click_pending = 1'b0;
			in_second = 1'b0;
			g = cfg.variant_mode ? bgc_pkg::GEST_VERY_LONG : bgc_pkg::GEST_LONG;
		end
		return g;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.debounce_time = bgc_pkg::RST_DEBOUNCE_TIME;
			cfg.double_click_window = bgc_pkg::RST_DOUBLE_CLICK_WINDOW;
			cfg.long_press_time = bgc_pkg::RST_LONG_PRESS_TIME;
			cfg.medium_hold_time = bgc_pkg::RST_MEDIUM_HOLD_TIME;
			cfg.very_long_time = bgc_pkg::RST_VERY_LONG_TIME;
			cfg.variant_mode = bgc_pkg::RST_VARIANT_MODE;
			raw_level = 1'b0;
			stable = 1'b0;
			cand_start = '0;
			press_start = '0;
			click_deadline = '0;
			click_pending = 1'b0;
			in_second = 1'b0;
			long_fired = 1'b0;
			gesture_q.delete();
			outstanding = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					bgc_pkg::REG_DEBOUNCE_TIME:       cfg.debounce_time = cfg_data;
					bgc_pkg::REG_DOUBLE_CLICK_WINDOW: cfg.double_click_window = cfg_data;
					bgc_pkg::REG_LONG_PRESS_TIME:     cfg.long_press_time = cfg_data;
					bgc_pkg::REG_MEDIUM_HOLD_TIME:    cfg.medium_hold_time = cfg_data;
					bgc_pkg::REG_VERY_LONG_TIME:      cfg.very_long_time = cfg_data;
					bgc_pkg::REG_VARIANT_MODE:        cfg.variant_mode = cfg_data[0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (gesture_q.size() == 0) begin
					report_mismatch($sformatf("gesture beat %0d with none expected", gesture));
				end else begin
					want = gesture_q.pop_front();
					if (gesture !== want)
						report_mismatch($sformatf("gesture %0d, expected %0d", gesture, want));
				end
			end
			if (in_valid && in_ready)
				gesture_q.push_back(classify_sample(op, pressed, now_ms));
			outstanding = gesture_q.size();
		end
	end

endmodule
`default_nettype wire

// ===== test/button_gesture_classifier_test.sv =====
`default_nettype none
module button_gesture_classifier_test;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 88;
	localparam int TW          = bgc_pkg::NOW_W;
	localparam int HW          = bgc_pkg::THR_W;
	localparam int IDX_W       = bgc_pkg::CFG_INDEX_W;
	localparam int DATA_W      = bgc_pkg::CFG_DATA_W;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               op = bgc_pkg::OP_SAMPLE;
	logic               pressed = 1'b0;
	logic [TW-1:0]      now_ms = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [2:0]         gesture;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [IDX_W-1:0]   cfg_index = '0;
	logic [DATA_W-1:0]  cfg_data = '0;

	int               outstanding;
	int               errors;
	int               cycles = 0;
	int               send_idle = 0;
	int               recv_stall = 0;
	bgc_pkg::cfg_t    cur_cfg;
	bgc_pkg::cfg_t    reset_cfg;
	logic [TW-1:0]    t_ms = '0;
	logic             level = 1'b0;

	button_gesture_classifier u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.pressed(pressed),
		.now_ms(now_ms),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.gesture(gesture),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	button_gesture_classifier_check u_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.pressed(pressed),
		.now_ms(now_ms),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.gesture(gesture),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.outstanding(outstanding),
		.errors(errors)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("button_gesture_classifier_test: done, errors");
			$finish;
		end
	end

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall);

	// Hold valid across back-to-back beats; drop it only while idling.
	task automatic send_item(input logic o, input logic l, input logic [TW-1:0] t);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		pressed <= l;
		now_ms <= t;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_regs(input bgc_pkg::cfg_t c);
		logic [IDX_W-1:0]  idx;
		logic [DATA_W-1:0] val;
		for (int i = 0; i < (1 << IDX_W); i++) begin
			idx = IDX_W'(i);
			val = DATA_W'($urandom());
			case (idx)
				bgc_pkg::REG_DEBOUNCE_TIME:       val = c.debounce_time;
				bgc_pkg::REG_DOUBLE_CLICK_WINDOW: val = c.double_click_window;
				bgc_pkg::REG_LONG_PRESS_TIME:     val = c.long_press_time;
				bgc_pkg::REG_MEDIUM_HOLD_TIME:    val = c.medium_hold_time;
				bgc_pkg::REG_VERY_LONG_TIME:      val = c.very_long_time;
				bgc_pkg::REG_VARIANT_MODE:        val[0] = c.variant_mode;
				default: ;
			endcase
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data <= val;
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		cur_cfg = c;
	endtask

	// Poll between edges so the checker's count is settled.
	task automatic wait_drained;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic run_random(input int count);
		int sent;
		int r;
		int span;
		int n;
		sent = 0;
		while (sent < count) begin
			r = $urandom_range(99);
			if (r < 4) begin
				level = 1'($urandom_range(0, 1));
				t_ms = $urandom();
				send_item(bgc_pkg::OP_RESTART, level, t_ms);
				sent++;
			end else if (r < 8) begin
				if ($urandom_range(0, 1))
					t_ms = $urandom();
				else
					t_ms = t_ms - $urandom_range(1, 100);
				send_item(bgc_pkg::OP_SAMPLE, 1'($urandom_range(0, 1)), t_ms);
				sent++;
			end else begin
				// One held level over roughly one threshold, with some bounce.
				if ($urandom_range(99) < 85)
					level = !level;
				case ($urandom_range(0, 5))
					0: span = 8;
					1: span = int'(cur_cfg.debounce_time);
					2: span = int'(cur_cfg.double_click_window);
					3: span = int'(cur_cfg.long_press_time);
					4: span = int'(cur_cfg.medium_hold_time);
					default: span = int'(cur_cfg.very_long_time);
				endcase
				n = $urandom_range(1, 6);
				for (int i = 0; i < n && sent < count; i++) begin
					t_ms = t_ms + $urandom_range(0, (2 * span) / n + 1);
					send_item(bgc_pkg::OP_SAMPLE, level ^ ($urandom_range(99) < 8), t_ms);
					sent++;
				end
			end
		end
	endtask

	initial begin
		reset_cfg.debounce_time = bgc_pkg::RST_DEBOUNCE_TIME;
		reset_cfg.double_click_window = bgc_pkg::RST_DOUBLE_CLICK_WINDOW;
		reset_cfg.long_press_time = bgc_pkg::RST_LONG_PRESS_TIME;
		reset_cfg.medium_hold_time = bgc_pkg::RST_MEDIUM_HOLD_TIME;
		reset_cfg.very_long_time = bgc_pkg::RST_VERY_LONG_TIME;
		reset_cfg.variant_mode = bgc_pkg::RST_VARIANT_MODE;
		cur_cfg = reset_cfg;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle = 35;
		recv_stall = 35;
		// Defaults after reset: single, double, long, backwards time, wrap.
		send_item(bgc_pkg::OP_SAMPLE, 1'b0, 32'd0);
		send_item(bgc_pkg::OP_SAMPLE, 1'b1, 32'd10);
		send_item(bgc_pkg::OP_SAMPLE, 1'b1, 32'd40);
		send_item(bgc_pkg::OP_SAMPLE, 1'b0, 32'd100);
		send_item(bgc_pkg::OP_SAMPLE, 1'b0, 32'd130);
		send_item(bgc_pkg::OP_SAMPLE, 1'b0, 32'd500);
		send_item(bgc_pkg::OP_SAMPLE, 1'b1, 32'd600);
		send_item(bgc_pkg::OP_SAMPLE, 1'b1, 32'd630);
		send_item(bgc_pkg::OP_SAMPLE, 1'b0, 32'd700);
		send_item(bgc_pkg::OP_SAMPLE, 1'b0, 32'd730);
		send_item(bgc_pkg::OP_SAMPLE, 1'b1, 32'd800);
		send_item(bgc_pkg::OP_SAMPLE, 1'b1, 32'd830);
		send_item(bgc_pkg::OP_SAMPLE, 1'b0, 32'd900);
		send_item(bgc_pkg::OP_SAMPLE, 1'b0, 32'd930);
		send_item(bgc_pkg::OP_SAMPLE, 1'b1, 32'd1000);
		send_item(bgc_pkg::OP_SAMPLE, 1'b1, 32'd1030);
		send_item(bgc_pkg::OP_SAMPLE, 1'b1, 32'd1830);
		send_item(bgc_pkg::OP_SAMPLE, 1'b0, 32'd1900);
		send_item(bgc_pkg::OP_SAMPLE, 1'b0, 32'd1930);
		send_item(bgc_pkg::OP_SAMPLE, 1'b1, 32'd1000);
		send_item(bgc_pkg::OP_SAMPLE, 1'b1, 32'd500);
		send_item(bgc_pkg::OP_RESTART, 1'b1, 32'hFFFF_FFF0);
		send_item(bgc_pkg::OP_SAMPLE, 1'b1, 32'h0000_0400);
		send_item(bgc_pkg::OP_RESTART, 1'b0, 32'hFFFF_FFFF);
		send_item(bgc_pkg::OP_SAMPLE, 1'b0, 32'd0);
		t_ms = '0;
		level = 1'b0;

		for (int p = 1; p <= 8; p++) begin
			in_valid <= 1'b0;
			wait_drained();
			case (p)
				1: write_regs(reset_cfg);
				2: begin
					cur_cfg = reset_cfg;
					cur_cfg.variant_mode = 1'b1;
					write_regs(cur_cfg);
				end
				3: write_regs('0);
				4: begin
					cur_cfg = '0;
					cur_cfg.variant_mode = 1'b1;
					write_regs(cur_cfg);
				end
				5: write_regs('1);
				6: begin
					cur_cfg = '1;
					cur_cfg.variant_mode = 1'b0;
					write_regs(cur_cfg);
				end
				7: begin
					cur_cfg.debounce_time = HW'($urandom_range(0, 2000));
					cur_cfg.double_click_window = HW'($urandom_range(0, 2000));
					cur_cfg.long_press_time = HW'($urandom_range(0, 2000));
					cur_cfg.medium_hold_time = HW'($urandom_range(0, 2000));
					cur_cfg.very_long_time = HW'($urandom_range(0, 2000));
					cur_cfg.variant_mode = 1'($urandom_range(0, 1));
					write_regs(cur_cfg);
				end
				default: begin
					cur_cfg.debounce_time = HW'($urandom_range(0, 65535));
					cur_cfg.double_click_window = HW'($urandom_range(0, 65535));
					cur_cfg.long_press_time = HW'($urandom_range(0, 65535));
					cur_cfg.medium_hold_time = HW'($urandom_range(0, 65535));
					cur_cfg.very_long_time = HW'($urandom_range(0, 65535));
					cur_cfg.variant_mode = 1'($urandom_range(0, 1));
					write_regs(cur_cfg);
				end
			endcase
			case (p % 4)
				0: begin
					send_idle = 0;
					recv_stall = 0;
				end
				1: begin
					send_idle = 56;
					recv_stall = 0;
				end
				2: begin
					send_idle = 0;
					recv_stall = 56;
				end
				default: begin
					send_idle = 35;
					recv_stall = 35;
				end
			endcase
			run_random(PHASE_ITEMS);
		end

		in_valid <= 1'b0;
		wait_drained();
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("button_gesture_classifier_test: done, clean");
		else
			$display("button_gesture_classifier_test: done, errors");
		$finish;
	end

endmodule
`default_nettype wire
